>>> src/rdc_pkg.sv
// rdc_pkg: shared constants and types for the radix digit converter
// field widths, radix limits, parameter defaults and the sequencer state type
// no dependencies
package rdc_pkg;

    // default sizes handed to the top level parameters
    localparam int VALUE_WIDTH_DEF = 31;
    localparam int MAX_DIGITS_DEF  = 32;

    // fixed field widths
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;

    // radix register reset and clamp limits
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_READ = 4'b0100,
        ST_SHOW = 4'b1000
    } rdc_state_t;

endpackage

>>> src/radix_digit_converter.sv
// radix_digit_converter: converts one unsigned integer to radix 2..16 digits
// bit-serial restoring divider, digit stack memory and output sequencer
// depends on rdc_pkg

// One request carries an unsigned value; the block answers with one output
// request per digit in the configured radix, most significant digit first,
// with last_digit set on the final one. Zero gives the single digit 0. The
// radix register (cfg_we/cfg_data) is clamped to 2..16 and must only be
// written while no conversion is in flight. Conversion is bit-serial: each
// division by the radix shifts the dividend through a 4-bit remainder stage
// one bit per clock. Each finished remainder is pushed onto the digit stack;
// digits are then emitted from the stack by a registered memory read followed
// by an output request that is held until out_ready accepts it. A new value is
// taken only after the last digit of the previous one has been accepted and
// the sequencer has returned to idle. If a value needs more than MAX_DIGITS
// digits, only the MAX_DIGITS least significant are emitted.
module radix_digit_converter #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_we,
    input  logic [rdc_pkg::RADIX_W-1:0] cfg_data,
    // input requests
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [VALUE_WIDTH-1:0]      value,
    // output requests
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rdc_pkg::DIGIT_W-1:0] digit,
    output logic                        last_digit
);
    import rdc_pkg::*;

    localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
    localparam int ADDR_W    = $clog2(MAX_DIGITS);
    localparam int COUNT_W   = $clog2(MAX_DIGITS + 1);
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_WIDTH - 1);
    localparam logic [COUNT_W-1:0]   STORE_FULL = COUNT_W'(MAX_DIGITS);

    rdc_state_t state_reg, state_next;

    logic [RADIX_W-1:0]     radix_reg;
    logic [RADIX_W-1:0]     radix_eff;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic                   qnz_reg, qnz_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   last_reg, last_next;

    logic [RADIX_W-1:0]     trial;
    logic [RADIX_W-1:0]     trial_diff;
    logic                   q_bit;
    logic [DIGIT_W-1:0]     rem_step;
    logic                   push;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;

    logic [DIGIT_W-1:0]     store_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]     rd_data_reg;

    // radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_data;
        end
    end

    // clamp radix into 2..16
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            radix_eff = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            radix_eff = RADIX_MAX;
        end
        else
        begin
            radix_eff = radix_reg;
        end
    end

    // one restoring division step: remainder stays below the radix
    assign trial      = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign q_bit      = (trial >= radix_eff);
    assign trial_diff = trial - radix_eff;
    assign rem_step   = q_bit ? trial_diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        qnz_next     = qnz_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        push         = 1'b0;
        rd_en        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    quo_next     = value;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    qnz_next     = 1'b0;
                    count_next   = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = {quo_reg[VALUE_WIDTH-2:0], q_bit};
                rem_next = rem_step;
                qnz_next = qnz_reg | q_bit;
                if (bit_cnt_reg == LAST_BIT)
                begin
                    // remainder complete: push it, then divide again or drain
                    push = 1'b1;
                    if (count_reg != STORE_FULL)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    bit_cnt_next = '0;
                    rem_next     = '0;
                    qnz_next     = 1'b0;
                    if (!(qnz_reg | q_bit))
                    begin
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                end
            end
            ST_READ:
            begin
                // pop the top of the digit stack
                rd_en      = 1'b1;
                count_next = count_reg - COUNT_W'(1);
                last_next  = (count_next == '0);
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_ready)
                begin
                    state_next = last_reg ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = count_next[ADDR_W-1:0];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            qnz_reg     <= 1'b0;
            count_reg   <= '0;
            last_reg    <= 1'b0;
            quo_reg     <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            qnz_reg     <= qnz_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
        end
    end

    // digit stack write, dropped once full
    always_ff @(posedge clk)
    begin
        if (push && (count_reg != STORE_FULL))
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= rem_step;
        end
    end

    // digit stack read, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // handshake and outputs
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_SHOW);
    assign digit      = rd_data_reg;
    assign last_digit = last_reg;

endmodule
